>>> hw/rtl/edlm_pkg.sv
// ---------------------------------------------------------------------------
// edlm_pkg
// Shared types and constants for the emergency-stop debounce latch monitor.
// ---------------------------------------------------------------------------
package edlm_pkg;

   localparam int TIMER_BITS_DEFAULT = 16;
   localparam int DEBOUNCE_W         = 10;
   localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 10'd30;

   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 72;

   typedef enum logic [2:0] {
      EV_NONE     = 3'd0,
      EV_PRESS    = 3'd1,
      EV_RELEASE  = 3'd2,
      EV_NOISE    = 3'd3,
      EV_REFUSED  = 3'd4
   } event_type;

   typedef struct packed {
      logic clear_request;
      logic release_request;
      logic raw_level;
   } req_item_type;

   // last member sits in the lowest bits
   typedef struct packed {
      logic [2:0]  event_code;
      logic [15:0] longest_bounce_ticks;
      logic [7:0]  worst_edges;
      logic [15:0] last_bounce_ticks;
      logic [7:0]  last_edges;
      logic [15:0] press_total;
      logic        latch_set;
      logic        stop_active;
   } rsp_item_type;

   localparam int RSP_ITEM_W = $bits(rsp_item_type);

endpackage

>>> hw/rtl/edlm_in_stage.sv
// ---------------------------------------------------------------------------
// edlm_in_stage
// Input register: holds one request until the core takes it.
// ---------------------------------------------------------------------------
module edlm_in_stage
   import edlm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  take,
   output logic                  item_valid,
   output req_item_type          item
);

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;

   // free slot, or the held request leaves this cycle
   assign req_tready = !valid_ff || take;
   assign valid_in   = (req_tvalid && req_tready) || (valid_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff <= req_tdata[$bits(req_item_type)-1:0];
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

>>> hw/rtl/edlm_core.sv
// ---------------------------------------------------------------------------
// edlm_core
// Debounce state, sticky latch and bounce statistics; one tick per take.
// ---------------------------------------------------------------------------
module edlm_core
   import edlm_pkg::*;
#(
   parameter int TIMER_BITS = TIMER_BITS_DEFAULT
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [DEBOUNCE_W-1:0] csr_wdata,
   input  logic                  take,
   input  req_item_type          item,
   output rsp_item_type          result
);

   localparam int CMP_W = (TIMER_BITS > DEBOUNCE_W) ? TIMER_BITS : DEBOUNCE_W;
   localparam int AGE_W = (TIMER_BITS > 16) ? TIMER_BITS : 16;
   localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

   logic [DEBOUNCE_W-1:0] debounce_ff;
   logic                  prev_raw_ff,  prev_raw_in;
   logic                  stable_ff,    stable_in;
   logic                  in_trans_ff,  in_trans_in;
   logic [TIMER_BITS-1:0] quiet_ff,     quiet_in;
   logic [TIMER_BITS-1:0] age_ff,       age_in;
   logic [TIMER_BITS-1:0] edge_age_ff,  edge_age_in;
   logic [7:0]            edges_ff,     edges_in;
   logic                  latch_ff,     latch_in;
   logic [15:0]           press_ff,     press_in;
   logic [7:0]            worst_ff,     worst_in;
   logic [15:0]           longest_ff,   longest_in;
   logic [15:0]           recent_ff,    recent_in;
   event_type             ev;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= DEBOUNCE_RESET;
      end else if (csr_we) begin
         debounce_ff <= csr_wdata;
      end
   end

   always_comb begin
      logic [AGE_W-1:0] age_ext;
      prev_raw_in = prev_raw_ff;
      stable_in   = stable_ff;
      in_trans_in = in_trans_ff;
      quiet_in    = quiet_ff;
      age_in      = age_ff;
      edge_age_in = edge_age_ff;
      edges_in    = edges_ff;
      latch_in    = latch_ff;
      press_in    = press_ff;
      worst_in    = worst_ff;
      longest_in  = longest_ff;
      recent_in   = recent_ff;
      ev          = EV_NONE;
      age_ext     = '0;

      // advance timers of an open transition
      if (in_trans_ff) begin
         if (quiet_ff != TIMER_MAX) quiet_in = quiet_ff + 1'b1;
         if (age_ff != TIMER_MAX)   age_in   = age_ff + 1'b1;
      end

      if (item.raw_level != prev_raw_ff) begin
         prev_raw_in = item.raw_level;
         if (!in_trans_ff) begin
            in_trans_in = 1'b1;
            age_in      = '0;
            edges_in    = '0;
         end
         quiet_in    = '0;
         edge_age_in = age_in;
         if (edges_in != 8'hFF) edges_in = edges_in + 1'b1;
      end

      if (in_trans_in && (CMP_W'(quiet_in) > CMP_W'(debounce_ff))) begin
         in_trans_in = 1'b0;
         if (item.raw_level != stable_ff) begin
            stable_in = item.raw_level;
            age_ext   = AGE_W'(edge_age_in);
            recent_in = (age_ext > AGE_W'(16'hFFFF)) ? 16'hFFFF : age_ext[15:0];
            if (edges_in > worst_ff)    worst_in   = edges_in;
            if (recent_in > longest_ff) longest_in = recent_in;
            if (item.raw_level) begin
               latch_in = 1'b1;
               if (press_ff != 16'hFFFF) press_in = press_ff + 1'b1;
               ev = EV_PRESS;
            end else begin
               ev = EV_RELEASE;
            end
         end else begin
            ev = EV_NOISE;
         end
      end

      // refuse release while the contact is still pressed
      if (item.release_request) begin
         if (stable_in) begin
            if (ev == EV_NONE) ev = EV_REFUSED;
         end else begin
            latch_in = 1'b0;
         end
      end

      if (item.clear_request) begin
         press_in   = '0;
         worst_in   = '0;
         longest_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_raw_ff <= 1'b0;
         stable_ff   <= 1'b0;
         in_trans_ff <= 1'b0;
         quiet_ff    <= '0;
         age_ff      <= '0;
         edge_age_ff <= '0;
         edges_ff    <= '0;
         latch_ff    <= 1'b0;
         press_ff    <= '0;
         worst_ff    <= '0;
         longest_ff  <= '0;
         recent_ff   <= '0;
      end else if (take) begin
         prev_raw_ff <= prev_raw_in;
         stable_ff   <= stable_in;
         in_trans_ff <= in_trans_in;
         quiet_ff    <= quiet_in;
         age_ff      <= age_in;
         edge_age_ff <= edge_age_in;
         edges_ff    <= edges_in;
         latch_ff    <= latch_in;
         press_ff    <= press_in;
         worst_ff    <= worst_in;
         longest_ff  <= longest_in;
         recent_ff   <= recent_in;
      end
   end

   always_comb begin
      result.stop_active          = stable_in;
      result.latch_set            = latch_in;
      result.press_total          = press_in;
      result.last_edges           = edges_in;
      result.last_bounce_ticks    = recent_in;
      result.worst_edges          = worst_in;
      result.longest_bounce_ticks = longest_in;
      result.event_code           = ev;
   end

endmodule

>>> hw/rtl/edlm_out_stage.sv
// ---------------------------------------------------------------------------
// edlm_out_stage
// Result register: holds one result until the consumer takes it.
// ---------------------------------------------------------------------------
module edlm_out_stage
   import edlm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  rsp_item_type          result,
   output logic                  free,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic         valid_ff;
   logic         valid_in;
   rsp_item_type result_ff;

   assign free     = !valid_ff || rsp_tready;
   assign valid_in = load || (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-RSP_ITEM_W){1'b0}}, result_ff};

endmodule

>>> hw/rtl/estop_debounce_latch_monitor_unit.sv
// ---------------------------------------------------------------------------
// estop_debounce_latch_monitor_unit
// Emergency-stop contact debouncer with sticky latch and bounce statistics.
// ---------------------------------------------------------------------------
// Each request is one millisecond tick and gives exactly one response. The
// unit takes one request per clock cycle while the response side keeps up; a
// request passes through the input register, then the single-pass state
// update into the result register. Back-pressure on the response side stalls
// the input only when both registers are full. Write csr_wdata (debounce
// window, reset 30) only while no request is in flight.
module estop_debounce_latch_monitor_unit
   import edlm_pkg::*;
#(
   parameter int TIMER_BITS = TIMER_BITS_DEFAULT
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [DEBOUNCE_W-1:0] csr_wdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // raw_level, release_request, clear_request, zero pad
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // stop_active, latch_set, press_total[16], last_edges[8],
   // last_bounce_ticks[16], worst_edges[8], longest_bounce_ticks[16],
   // event_code[3], zero pad
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic         item_valid;
   req_item_type item;
   rsp_item_type result;
   logic         out_free;
   logic         take;

   assign take = item_valid && out_free;

   edlm_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .take       (take),
      .item_valid (item_valid),
      .item       (item)
   );

   edlm_core #(
      .TIMER_BITS (TIMER_BITS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .take      (take),
      .item      (item),
      .result    (result)
   );

   edlm_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (take),
      .result     (result),
      .free       (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

>>> hw/rtl/edlm_checker.sv
// ---------------------------------------------------------------------------
// edlm_checker
// Port-level checks for the debounce latch monitor, bound to the top level.
// ---------------------------------------------------------------------------
module edlm_checker
   import edlm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata
);

   // hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   a_press_latches: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[68:66] == EV_PRESS) |-> rsp_tdata[0] && rsp_tdata[1])
      else $error("press accepted without stop and latch");

   a_release_level: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[68:66] == EV_RELEASE) |-> !rsp_tdata[0])
      else $error("release accepted while stop active");

   a_refused_level: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[68:66] == EV_REFUSED) |-> rsp_tdata[0] && rsp_tdata[1])
      else $error("release refused while contact released or latch clear");

endmodule

bind estop_debounce_latch_monitor_unit edlm_checker u_edlm_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
